// ===== rtl/core/fes_pkg.sv =====
package fes_pkg;

   localparam int PIX_W  = 8;
   localparam int LW_W   = 11;
   localparam int OFF_W  = 10;
   localparam int SUM_W  = 11;
   localparam int CSR_W  = 11;

   localparam logic [LW_W-1:0]  LINE_WIDTH_RESET   = LW_W'(320);
   localparam logic [OFF_W-1:0] DECAY_OFFSET_RESET = OFF_W'(4);
   localparam int               LINE_WIDTH_MIN     = 2;

   // floor(x / 5) == (x * RECIP_5) >> RECIP_SHIFT for every x below 256*5
   localparam int RECIP_W     = 14;
   localparam int RECIP_SHIFT = 16;
   localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'(13108);

   typedef enum logic [0:0] {
      CSR_LINE_WIDTH   = 1'b0,
      CSR_DECAY_OFFSET = 1'b1
   } fes_csr_type;

   // near: current pixel plus the pixel two back; far: the three pixels one row up
   typedef struct packed {
      logic [PIX_W:0]         near;
      logic [3*PIX_W-1:0]     far;
   } fes_tap_type;

endpackage

// ===== rtl/core/fes_window.sv =====
module fes_window import fes_pkg::*; #(
   parameter  int MAX_WIDTH = 1024,
   localparam int ADDR_W    = $clog2(MAX_WIDTH + 3)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [PIX_W-1:0]   pixel,
   input  logic [ADDR_W-1:0]  width,
   output fes_tap_type        taps
);

   localparam int DEPTH = 2 ** ADDR_W;

   // each entry holds a pixel and the two before it, so one read gives a row-up triple
   logic [3*PIX_W-1:0] mem [DEPTH];

   logic [ADDR_W-1:0]  wr_ptr_ff;
   logic [ADDR_W-1:0]  wr_ptr_in;
   logic [ADDR_W-1:0]  rd_addr;
   logic [PIX_W-1:0]   prev1_ff;
   logic [PIX_W-1:0]   prev2_ff;
   logic [PIX_W:0]     near_ff;
   logic [3*PIX_W-1:0] rd_data_ff;

   assign wr_ptr_in = wr_ptr_ff + ADDR_W'(1);
   assign rd_addr   = wr_ptr_in - width;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
      end else if (accept) begin
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mem[wr_ptr_in] <= {pixel, prev1_ff, prev2_ff};
         rd_data_ff     <= mem[rd_addr];
         prev1_ff       <= pixel;
         prev2_ff       <= prev1_ff;
         near_ff        <= {1'b0, pixel} + {1'b0, prev2_ff};
      end
   end

   assign taps.near = near_ff;
   assign taps.far  = rd_data_ff;

endmodule

// ===== rtl/core/fes_decay.sv =====
module fes_decay import fes_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  fes_tap_type        taps,
   input  logic [OFF_W-1:0]   decay_offset,
   output logic               in_free,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [PIX_W-1:0]   rsp_heat_out
);

   localparam int PROD_W = SUM_W + RECIP_W;

   logic               s1_valid_ff;
   logic               s1_valid_in;
   logic [SUM_W-1:0]   diff_ff;
   logic [SUM_W-1:0]   diff_in;
   logic [SUM_W-1:0]   sum;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [PIX_W-1:0]   heat_ff;
   logic [PROD_W-1:0]  product;
   logic               out_take;

   assign out_take = !rsp_valid_ff || rsp_ready;
   assign in_free  = !s1_valid_ff || out_take;

   assign sum = SUM_W'(taps.near)
              + SUM_W'(taps.far[3*PIX_W-1:2*PIX_W])
              + SUM_W'(taps.far[2*PIX_W-1:PIX_W])
              + SUM_W'(taps.far[PIX_W-1:0]);

   always_comb begin
      if (sum > SUM_W'(decay_offset)) begin
         diff_in = sum - SUM_W'(decay_offset);
      end else begin
         diff_in = '0;
      end
   end

   assign product = PROD_W'(diff_ff) * PROD_W'(RECIP_5);

   assign s1_valid_in  = in_free ? in_valid : s1_valid_ff;
   assign rsp_valid_in = out_take ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_free && in_valid) begin
         diff_ff <= diff_in;
      end
      if (out_take && s1_valid_ff) begin
         heat_ff <= product[RECIP_SHIFT +: PIX_W];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_heat_out = heat_ff;

endmodule

// ===== rtl/core/fire_effect_stencil_unit.sv =====
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  req_heat_in[7:0], req_frame_start
// rsp_      out        rsp_valid / rsp_ready  rsp_heat_out[7:0]
// csr_      in         csr_write_en           csr_index (0 width, 1 offset), csr_wdata[10:0]
//
// One request per cycle while req_ready is high; a result for the request that completes
// its window passes the window memory read, sum and subtract, and reciprocal multiply.
// Single-port-write, single-read window memory holds pixel triples, so one read per
// request covers all three row-up taps; no clearing pass follows reset.
// Reset clears the fill count, write pointer and pipeline valids; registers take
// width 320, offset 4.
// A stalled rsp_ready fills the output, sum and read stages before req_ready drops.
module fire_effect_stencil_unit import fes_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [PIX_W-1:0]   req_heat_in,
   input  logic               req_frame_start,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [PIX_W-1:0]   rsp_heat_out,
   input  logic               csr_write_en,
   input  fes_csr_type        csr_index,
   input  logic [CSR_W-1:0]   csr_wdata
);

   localparam int ADDR_W = $clog2(MAX_WIDTH + 3);
   localparam int CNT_W  = $clog2(2 * MAX_WIDTH + 3);

   logic [LW_W-1:0]   line_width_ff;
   logic [OFF_W-1:0]  decay_offset_ff;
   logic [CNT_W-1:0]  fill_count_ff;
   logic [CNT_W-1:0]  fill_count_in;
   logic [CNT_W-1:0]  fill_base;
   logic [CNT_W-1:0]  need;
   logic [ADDR_W-1:0] width_eff;
   logic              s0_valid_ff;
   logic              s0_valid_in;
   logic              s1_free;
   logic              req_accept;
   logic              fire;
   fes_tap_type       taps;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= LINE_WIDTH_RESET;
         decay_offset_ff <= DECAY_OFFSET_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_LINE_WIDTH: begin
               line_width_ff <= csr_wdata[LW_W-1:0];
            end
            CSR_DECAY_OFFSET: begin
               decay_offset_ff <= csr_wdata[OFF_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // clamp the line width into [2, MAX_WIDTH]
   always_comb begin
      if (32'(line_width_ff) < LINE_WIDTH_MIN) begin
         width_eff = ADDR_W'(LINE_WIDTH_MIN);
      end else if (32'(line_width_ff) > MAX_WIDTH) begin
         width_eff = ADDR_W'(MAX_WIDTH);
      end else begin
         width_eff = ADDR_W'(line_width_ff);
      end
   end

   assign need = CNT_W'({width_eff, 1'b0}) + CNT_W'(2);

   assign req_ready  = !s0_valid_ff || s1_free;
   assign req_accept = req_valid && req_ready;

   // restart the fill on frame start, saturate at a full window
   assign fill_base     = req_frame_start ? '0 : fill_count_ff;
   assign fill_count_in = (fill_base >= need) ? need : fill_base + CNT_W'(1);
   assign fire          = (fill_count_in == need);

   always_comb begin
      if (req_accept) begin
         s0_valid_in = fire;
      end else if (s1_free) begin
         s0_valid_in = 1'b0;
      end else begin
         s0_valid_in = s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
         s0_valid_ff   <= 1'b0;
      end else begin
         if (req_accept) begin
            fill_count_ff <= fill_count_in;
         end
         s0_valid_ff <= s0_valid_in;
      end
   end

   fes_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_window (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .pixel  (req_heat_in),
      .width  (width_eff),
      .taps   (taps)
   );

   fes_decay u_decay (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s0_valid_ff),
      .taps         (taps),
      .decay_offset (decay_offset_ff),
      .in_free      (s1_free),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_heat_out (rsp_heat_out)
   );

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= CNT_W'(2 * MAX_WIDTH + 2))
      else $error("fill count beyond the largest window");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_frame_start |=> !s0_valid_ff)
      else $error("first pixel of a frame produced a result");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s0_valid_ff && rsp_valid && !rsp_ready)
      else $error("request stalled while the pipeline has room");

   a_window_filled: assert property (@(posedge clock) disable iff (reset)
      s0_valid_ff |-> fill_count_ff >= CNT_W'(6))
      else $error("result issued before the window filled");
`endif

endmodule
